// File: design/vgqm_pkg.sv
// ----------------------------------------------------------------------------
// vgqm_pkg
// shared types and constants of the voxel greedy quad mesher
// ----------------------------------------------------------------------------
package vgqm_pkg;

    // chunk geometry
    localparam int CW         = 16;
    localparam int CD         = 64;
    localparam int VS         = CW + 1;
    localparam int VOL_DEPTH  = VS * CD * VS;
    localparam int VOL_AW     = $clog2(VOL_DEPTH);
    localparam int MASK_DEPTH = (CW > CD) ? (CW * CW) : (CW * CD);
    localparam int MASK_AW    = $clog2(MASK_DEPTH);
    localparam int MAXD       = (CW > CD) ? CW : CD;
    localparam int CNT_W      = $clog2(MAXD + 1);

    // request codes on the input channel
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_RESTART = 2'd1;
    localparam logic [1:0] REQ_PULL    = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    // register indexes
    localparam logic [1:0] REG_WATER   = 2'd0;
    localparam logic [1:0] REG_LEAVES  = 2'd1;
    localparam logic [1:0] REG_GLASS   = 2'd2;
    localparam logic [1:0] REG_UNKNOWN = 2'd3;

    // normal axes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // face type codes
    localparam logic [2:0] FT_POS_Z = 3'd0;
    localparam logic [2:0] FT_NEG_Z = 3'd1;
    localparam logic [2:0] FT_POS_Y = 3'd2;
    localparam logic [2:0] FT_NEG_Y = 3'd3;
    localparam logic [2:0] FT_POS_X = 3'd4;
    localparam logic [2:0] FT_NEG_X = 3'd5;

    // face direction codes in the mask key
    localparam logic [1:0] DIR_LOWER = 2'd1;
    localparam logic [1:0] DIR_UPPER = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_RESTART,
        CMD_PULL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] x;
        logic [5:0] y;
        logic [4:0] z;
        logic [7:0] blk;
    } t_cmd;

    typedef struct packed {
        logic [7:0] water;
        logic [7:0] leaves;
        logic [7:0] glass;
    } t_ids;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PULL,
        S_BRD,
        S_BWR,
        S_SRD,
        S_SCHK,
        S_WRD,
        S_WCHK,
        S_HRD,
        S_HCHK,
        S_CLR,
        S_EMIT,
        S_ENDSCAN
    } t_state;

endpackage

// File: design/vgqm_fifo.sv
// ----------------------------------------------------------------------------
// vgqm_fifo
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module vgqm_fifo
    import vgqm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: design/vgqm_front.sv
// ----------------------------------------------------------------------------
// vgqm_front
// accepts requests, drops invalid ones and queues commands for the back
// ----------------------------------------------------------------------------
module vgqm_front
    import vgqm_pkg::*;
(
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_req_type,
    input  logic [4:0] i_cell_x,
    input  logic [5:0] i_cell_y,
    input  logic [4:0] i_cell_z,
    input  logic [7:0] i_cell_block,
    input  logic       i_busy,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic accept;
    logic in_range;

    assign o_stall  = i_full || i_busy;
    assign accept   = i_valid && !o_stall;
    // the coordinate ports are at least wide enough for the chunk, so plain compares
    assign in_range = (i_cell_x <= 5'(CW)) && (i_cell_z <= 5'(CW))
                    && ({1'b0, i_cell_y} < 7'(CD));

    always_comb begin
        o_cmd.x   = i_cell_x;
        o_cmd.y   = i_cell_y;
        o_cmd.z   = i_cell_z;
        o_cmd.blk = i_cell_block;
        o_cmd.op  = CMD_WRITE;
        o_push    = 1'b0;
        case (i_req_type)
            REQ_WRITE: begin
                o_push = accept && in_range;
            end
            REQ_RESTART: begin
                o_cmd.op = CMD_RESTART;
                o_push   = accept;
            end
            REQ_PULL: begin
                o_cmd.op = CMD_PULL;
                o_push   = accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// File: design/vgqm_back.sv
// ----------------------------------------------------------------------------
// vgqm_back
// volume store, face mask and the mask build / greedy merge sequencer
// ----------------------------------------------------------------------------
module vgqm_back
    import vgqm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ids       i_ids,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_busy,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_quad_valid,
    output logic       o_scan_done,
    output logic [1:0] o_axis,
    output logic       o_toward_positive,
    output logic [2:0] o_face_type,
    output logic [7:0] o_block_type,
    output logic [6:0] o_plane,
    output logic [5:0] o_u_start,
    output logic [5:0] o_v_start,
    output logic [6:0] o_quad_width,
    output logic [6:0] o_quad_height
);

    typedef struct packed {
        logic              ok;
        logic [VOL_AW-1:0] addr;
    } t_vref;

    function automatic t_vref vol_ref(input logic [1:0] axis, input logic [CNT_W-1:0] c,
                                      input logic [CNT_W-1:0] i, input logic [CNT_W-1:0] j);
        logic [CNT_W-1:0] x;
        logic [CNT_W-1:0] y;
        logic [CNT_W-1:0] z;
        t_vref            res;
        case (axis)
            AXIS_X: begin
                x = c; y = i; z = j;
            end
            AXIS_Y: begin
                y = c; z = i; x = j;
            end
            default: begin
                z = c; x = i; y = j;
            end
        endcase
        res.ok   = (x <= CNT_W'(CW)) && (y < CNT_W'(CD)) && (z <= CNT_W'(CW));
        res.addr = VOL_AW'((int'(x) * CD + int'(y)) * VS + int'(z));
        return res;
    endfunction

    function automatic logic [MASK_AW-1:0] mask_idx(input logic [1:0] axis,
                                                    input logic [CNT_W-1:0] i,
                                                    input logic [CNT_W-1:0] j);
        int row;
        row = (axis == AXIS_X) ? int'(j) * CD : int'(j) * CW;
        return MASK_AW'(row + int'(i));
    endfunction

    function automatic logic [9:0] face_of(input logic [7:0] b1, input logic [7:0] b2,
                                           input t_ids ids);
        logic st1;
        logic st2;
        logic d1;
        logic d2;
        logic [9:0] res;
        st1 = (b1 == 8'd0) || (b1 == ids.leaves) || (b1 == ids.water) || (b1 == ids.glass);
        st2 = (b2 == 8'd0) || (b2 == ids.leaves) || (b2 == ids.water) || (b2 == ids.glass);
        d1  = (b1 != 8'd0) && (b1 != ids.water) && st2;
        d2  = (b2 != 8'd0) && (b2 != ids.water) && st1;
        if (b1 == ids.water && b2 == 8'd0) begin
            d1 = 1'b1;
        end
        if (b2 == ids.water && b1 == 8'd0) begin
            d2 = 1'b1;
        end
        res = 10'd0;
        if (b1 == b2) begin
            res = 10'd0;
        end else if (d1) begin
            res = {DIR_LOWER, b1};
        end else if (d2) begin
            res = {DIR_UPPER, b2};
        end
        return res;
    endfunction

    // memories
    logic [7:0] r_vol  [VOL_DEPTH];
    logic [9:0] r_mask [MASK_DEPTH];

    // control state
    t_state            r_state, n_state;
    logic [VOL_AW-1:0] r_clr, n_clr;
    logic [1:0]        r_axis, n_axis;
    logic [CNT_W-1:0]  r_plane, n_plane;
    logic              r_built, n_built;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_ci, n_ci;
    logic [CNT_W-1:0]  r_cj, n_cj;
    logic              r_ovalid, n_ovalid;

    // quad under construction
    logic [9:0]        r_key, n_key;
    logic [CNT_W-1:0]  r_qi, n_qi;
    logic [CNT_W-1:0]  r_qj, n_qj;
    logic [CNT_W-1:0]  r_w, n_w;
    logic [CNT_W-1:0]  r_h, n_h;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_l, n_l;

    // memory read data
    logic [7:0]        r_rd1;
    logic [7:0]        r_rd2;
    logic              r_ok1;
    logic              r_ok2;
    logic [9:0]        r_mrd;

    // memory controls
    logic              vol_we;
    logic [VOL_AW-1:0] vol_wa;
    logic [7:0]        vol_wd;
    logic              mask_we;
    logic [MASK_AW-1:0] mask_wa;
    logic [9:0]        mask_wd;
    logic [MASK_AW-1:0] mask_ra;
    logic              out_load;
    logic              out_done;

    logic [CNT_W-1:0]  du;
    logic [CNT_W-1:0]  dv;
    logic [CNT_W-1:0]  nl;
    logic [CNT_W:0]    qi_w;
    logic [CNT_W:0]    qj_h;
    logic [CNT_W-1:0]  k_next;
    logic [CNT_W-1:0]  l_next;
    logic              out_free;
    t_vref             a1;
    t_vref             a2;
    logic [VOL_AW-1:0] cmd_addr;
    logic              dir_lower;

    assign du       = (r_axis == AXIS_X) ? CNT_W'(CD) : CNT_W'(CW);
    assign dv       = (r_axis == AXIS_Z) ? CNT_W'(CD) : CNT_W'(CW);
    assign nl       = (r_axis == AXIS_Y) ? CNT_W'(CD) : CNT_W'(CW);
    assign qi_w     = {1'b0, r_qi} + {1'b0, r_w};
    assign qj_h     = {1'b0, r_qj} + {1'b0, r_h};
    assign k_next   = r_k + CNT_W'(1);
    assign l_next   = r_l + CNT_W'(1);
    assign out_free = !r_ovalid || !i_stall;
    assign a1       = vol_ref(r_axis, r_plane - CNT_W'(1), r_ci, r_cj);
    assign a2       = vol_ref(r_axis, r_plane, r_ci, r_cj);
    assign cmd_addr = VOL_AW'((int'(i_cmd.x) * CD + int'(i_cmd.y)) * VS + int'(i_cmd.z));
    assign o_busy   = (r_state == S_CLEAR);
    assign o_valid  = r_ovalid;
    assign dir_lower = (r_key[9:8] == DIR_LOWER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_axis   <= AXIS_X;
            r_plane  <= '0;
            r_built  <= 1'b0;
            r_done   <= 1'b0;
            r_ci     <= '0;
            r_cj     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_axis   <= n_axis;
            r_plane  <= n_plane;
            r_built  <= n_built;
            r_done   <= n_done;
            r_ci     <= n_ci;
            r_cj     <= n_cj;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_qi  <= n_qi;
        r_qj  <= n_qj;
        r_w   <= n_w;
        r_h   <= n_h;
        r_k   <= n_k;
        r_l   <= n_l;
        r_ok1 <= a1.ok && (r_plane != '0);
        r_ok2 <= a2.ok;
    end

    // volume store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (vol_we) begin
            r_vol[vol_wa] <= vol_wd;
        end
        r_rd1 <= r_vol[a1.addr];
        r_rd2 <= r_vol[a2.addr];
    end

    // face mask: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mask_we) begin
            r_mask[mask_wa] <= mask_wd;
        end
        r_mrd <= r_mask[mask_ra];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (out_done) begin
                o_quad_valid      <= 1'b0;
                o_scan_done       <= 1'b1;
                o_axis            <= 2'd0;
                o_toward_positive <= 1'b0;
                o_face_type       <= 3'd0;
                o_block_type      <= 8'd0;
                o_plane           <= 7'd0;
                o_u_start         <= 6'd0;
                o_v_start         <= 6'd0;
                o_quad_width      <= 7'd0;
                o_quad_height     <= 7'd0;
            end else begin
                o_quad_valid      <= 1'b1;
                o_scan_done       <= 1'b0;
                o_axis            <= r_axis;
                o_toward_positive <= dir_lower;
                case (r_axis)
                    AXIS_X:  o_face_type <= dir_lower ? FT_POS_X : FT_NEG_X;
                    AXIS_Y:  o_face_type <= dir_lower ? FT_POS_Y : FT_NEG_Y;
                    default: o_face_type <= dir_lower ? FT_POS_Z : FT_NEG_Z;
                endcase
                o_block_type      <= r_key[7:0];
                o_plane           <= 7'(r_plane);
                o_u_start         <= 6'(r_qi);
                o_v_start         <= 6'(r_qj);
                o_quad_width      <= 7'(r_w);
                o_quad_height     <= 7'(r_h);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_axis   = r_axis;
        n_plane  = r_plane;
        n_built  = r_built;
        n_done   = r_done;
        n_ci     = r_ci;
        n_cj     = r_cj;
        n_key    = r_key;
        n_qi     = r_qi;
        n_qj     = r_qj;
        n_w      = r_w;
        n_h      = r_h;
        n_k      = r_k;
        n_l      = r_l;
        o_pop    = 1'b0;
        vol_we   = 1'b0;
        vol_wa   = r_clr;
        vol_wd   = 8'd0;
        mask_we  = 1'b0;
        mask_wa  = mask_idx(r_axis, r_ci, r_cj);
        mask_wd  = 10'd0;
        mask_ra  = mask_idx(r_axis, r_ci, r_cj);
        out_load = 1'b0;
        out_done = 1'b0;

        case (r_state)
            S_CLEAR: begin
                vol_we = 1'b1;
                n_clr  = r_clr + VOL_AW'(1);
                if (r_clr == VOL_AW'(VOL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        CMD_WRITE: begin
                            vol_we = 1'b1;
                            vol_wa = cmd_addr;
                            vol_wd = i_cmd.blk;
                        end
                        CMD_RESTART: begin
                            n_axis  = AXIS_X;
                            n_plane = '0;
                            n_built = 1'b0;
                            n_done  = 1'b0;
                            n_ci    = '0;
                            n_cj    = '0;
                        end
                        CMD_PULL: begin
                            n_state = S_PULL;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PULL: begin
                if (r_done) begin
                    n_state = S_ENDSCAN;
                end else if (!r_built) begin
                    n_ci    = '0;
                    n_cj    = '0;
                    n_state = S_BRD;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_BRD: begin
                n_state = S_BWR;
            end
            S_BWR: begin
                mask_we = 1'b1;
                mask_wd = face_of(r_ok1 ? r_rd1 : 8'd0, r_ok2 ? r_rd2 : 8'd0, i_ids);
                n_state = S_BRD;
                if (r_ci == du - CNT_W'(1)) begin
                    n_ci = '0;
                    if (r_cj == dv - CNT_W'(1)) begin
                        n_cj    = '0;
                        n_built = 1'b1;
                        n_state = S_SRD;
                    end else begin
                        n_cj = r_cj + CNT_W'(1);
                    end
                end else begin
                    n_ci = r_ci + CNT_W'(1);
                end
            end
            S_SRD: begin
                if (r_cj == dv) begin
                    // layer exhausted: step to the next layer or axis, or mark the scan done after the last axis
                    n_built = 1'b0;
                    n_state = S_PULL;
                    if (r_plane == nl) begin
                        n_plane = '0;
                        if (r_axis == AXIS_Z) begin
                            n_axis = AXIS_X;
                            n_done = 1'b1;
                        end else begin
                            n_axis = r_axis + 2'd1;
                        end
                    end else begin
                        n_plane = r_plane + CNT_W'(1);
                    end
                end else if (r_ci >= du) begin
                    n_ci = '0;
                    n_cj = r_cj + CNT_W'(1);
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (r_mrd != 10'd0) begin
                    n_key   = r_mrd;
                    n_qi    = r_ci;
                    n_qj    = r_cj;
                    n_w     = CNT_W'(1);
                    n_state = S_WRD;
                end else begin
                    n_ci    = r_ci + CNT_W'(1);
                    n_state = S_SRD;
                end
            end
            S_WRD: begin
                mask_ra = mask_idx(r_axis, CNT_W'(qi_w), r_qj);
                if (qi_w < {1'b0, du}) begin
                    n_state = S_WCHK;
                end else begin
                    n_k     = '0;
                    n_h     = CNT_W'(1);
                    n_state = S_HRD;
                end
            end
            S_WCHK: begin
                if (r_mrd == r_key) begin
                    n_w     = r_w + CNT_W'(1);
                    n_state = S_WRD;
                end else begin
                    n_k     = '0;
                    n_h     = CNT_W'(1);
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                mask_ra = mask_idx(r_axis, r_qi + r_k, CNT_W'(qj_h));
                if (qj_h < {1'b0, dv}) begin
                    n_state = S_HCHK;
                end else begin
                    n_k     = '0;
                    n_l     = '0;
                    n_state = S_CLR;
                end
            end
            S_HCHK: begin
                if (r_mrd != r_key) begin
                    n_k     = '0;
                    n_l     = '0;
                    n_state = S_CLR;
                end else if (k_next == r_w) begin
                    n_k     = '0;
                    n_h     = r_h + CNT_W'(1);
                    n_state = S_HRD;
                end else begin
                    n_k     = k_next;
                    n_state = S_HRD;
                end
            end
            S_CLR: begin
                mask_we = 1'b1;
                mask_wa = mask_idx(r_axis, r_qi + r_k, r_qj + r_l);
                mask_wd = 10'd0;
                if (k_next == r_w) begin
                    n_k = '0;
                    if (l_next == r_h) begin
                        n_state = S_EMIT;
                    end else begin
                        n_l = l_next;
                    end
                end else begin
                    n_k = k_next;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_ci     = CNT_W'(qi_w);
                    n_cj     = r_qj;
                    n_state  = S_IDLE;
                end
            end
            S_ENDSCAN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_done = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

endmodule

// File: design/voxel_greedy_quad_mesher_unit.sv
// ----------------------------------------------------------------------------
// voxel_greedy_quad_mesher_unit
// greedy face mesher for one 16 x 64 x 16 voxel chunk with +x / +z borders
// ----------------------------------------------------------------------------
// After reset the block sweeps its 18496-entry volume store to air, one entry
// per cycle, and takes no transaction on the request channel while it does so
// (register writes on the apb port are taken all the time). Writes and
// restarts are then carried out by the back end as each is popped. A pull
// walks the scan: each new layer builds its face mask entry by entry (two
// volume reads, then one mask write), then the scan skips empty mask entries,
// changes rows, probes the width and then the height of a quad and clears its
// w x h mask entries before the quad is put out; a pull ends with one quad or
// with the scan done mark. The mask build through the single volume read
// stage and the single read port of the face mask set the pace of the scan.
// A two-entry command queue lets requests arrive while a pull runs; the result
// register lets the next request be queued while a result waits to be taken.
// ----------------------------------------------------------------------------
module voxel_greedy_quad_mesher_unit
    import vgqm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [4:0]  i_cell_x,
    input  logic [5:0]  i_cell_y,
    input  logic [4:0]  i_cell_z,
    input  logic [7:0]  i_cell_block,

    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_quad_valid,
    output logic        o_scan_done,
    output logic [1:0]  o_axis,
    output logic        o_toward_positive,
    output logic [2:0]  o_face_type,
    output logic [7:0]  o_block_type,
    output logic [6:0]  o_plane,
    output logic [5:0]  o_u_start,
    output logic [5:0]  o_v_start,
    output logic [6:0]  o_quad_width,
    output logic [6:0]  o_quad_height,

    // apb register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // see-through block ids
    t_ids r_ids;

    logic apb_wr;
    logic busy;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd q_in;
    t_cmd q_out;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ids.water  <= 8'd6;
            r_ids.leaves <= 8'd5;
            r_ids.glass  <= 8'd9;
        end else if (apb_wr) begin
            case (paddr[3:2])
                REG_WATER:  r_ids.water  <= pwdata[7:0];
                REG_LEAVES: r_ids.leaves <= pwdata[7:0];
                REG_GLASS:  r_ids.glass  <= pwdata[7:0];
                default:    r_ids        <= r_ids;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WATER:  prdata = {24'd0, r_ids.water};
            REG_LEAVES: prdata = {24'd0, r_ids.leaves};
            REG_GLASS:  prdata = {24'd0, r_ids.glass};
            default:    prdata = 32'd0;
        endcase
    end

    // front: accept and classify requests
    vgqm_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_cell_z     (i_cell_z),
        .i_cell_block (i_cell_block),
        .i_busy       (busy),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    // command queue
    vgqm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // back: volume, mask build and greedy merge
    vgqm_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ids             (r_ids),
        .i_empty           (q_empty),
        .i_cmd             (q_out),
        .o_pop             (q_pop),
        .o_busy            (busy),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_quad_valid      (o_quad_valid),
        .o_scan_done       (o_scan_done),
        .o_axis            (o_axis),
        .o_toward_positive (o_toward_positive),
        .o_face_type       (o_face_type),
        .o_block_type      (o_block_type),
        .o_plane           (o_plane),
        .o_u_start         (o_u_start),
        .o_v_start         (o_v_start),
        .o_quad_width      (o_quad_width),
        .o_quad_height     (o_quad_height)
    );

endmodule
